[rtl/watchdog_keepalive_controller_defines.svh]
// ----------------------------------------------------------------------------
// Watchdog keepalive controller assertion macros
// Shared property shorthands for the checker files of this block.
// ----------------------------------------------------------------------------
`ifndef WATCHDOG_KEEPALIVE_CONTROLLER_DEFINES_SVH
`define WATCHDOG_KEEPALIVE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WDKC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WDKC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/wdkc_pkg.sv]
// ----------------------------------------------------------------------------
// Watchdog keepalive controller package
// Event kinds, status codes, limits and the item/result types of the block.
// ----------------------------------------------------------------------------
package wdkc_pkg;

    localparam int unsigned TDATA_IN_W  = 24;
    localparam int unsigned TUSER_IN_W  = 4;
    localparam int unsigned TDATA_OUT_W = 16;

    localparam logic [15:0] MAX_TIMEOUT     = 16'd256;
    localparam logic [8:0]  DEFAULT_TIMEOUT = 9'd30;
    localparam logic [7:0]  MAGIC_BYTE      = 8'h56;

    typedef enum logic [2:0] {
        KIND_TICK        = 3'd0,
        KIND_OPEN        = 3'd1,
        KIND_CLOSE       = 3'd2,
        KIND_WRITE       = 3'd3,
        KIND_KEEPALIVE   = 3'd4,
        KIND_SET_TIMEOUT = 3'd5,
        KIND_GET_TIMEOUT = 3'd6,
        KIND_SET_OPTIONS = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BUSY    = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    // Option bits of a set-options request
    localparam int unsigned OPT_DISABLE = 0;
    localparam int unsigned OPT_ENABLE  = 1;

    typedef struct packed {
        logic               first_of_write;
        kind_t              kind;
        logic signed [9:0]  argument_value;
        logic [7:0]         data_byte;
    } item_t;

    // Packed so that status lands in the lowest bits of m_tdata
    typedef struct packed {
        logic       is_running;
        logic       system_reset;
        logic       hw_stop;
        logic       hw_reload;
        logic [8:0] timeout_value;
        status_t    status;
    } result_t;

endpackage

[rtl/wdkc_core.sv]
// ----------------------------------------------------------------------------
// Watchdog keepalive core
// Holds the countdown and flags and turns one event into one result.
// ----------------------------------------------------------------------------
module wdkc_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             no_way_out,
    input  wdkc_pkg::item_t  item,
    output wdkc_pkg::result_t result
);
    import wdkc_pkg::*;

    logic [8:0] countdown_reg, countdown_next;
    logic       running_reg, running_next;
    logic       opened_reg, opened_next;
    logic       magic_reg, magic_next;
    logic [8:0] timeout_reg, timeout_next;

    logic       start_expire;
    logic [8:0] start_count;
    logic       tick_expire;
    logic       arg_ok;

    // Start reloads and ticks once right away
    assign start_expire = (timeout_reg <= 9'd1);
    assign start_count  = start_expire ? 9'd0 : timeout_reg - 9'd1;
    assign tick_expire  = (countdown_reg <= 9'd1);

    assign arg_ok = !item.argument_value[9] && (item.argument_value[8:0] != 9'd0)
                    && ({7'd0, item.argument_value[8:0]} <= MAX_TIMEOUT);

    always_comb begin
        countdown_next = countdown_reg;
        running_next   = running_reg;
        opened_next    = opened_reg;
        magic_next     = magic_reg;
        timeout_next   = timeout_reg;
        result         = '0;
        result.status  = STATUS_OK;

        case (item.kind)
            KIND_TICK: begin
                if (running_reg) begin
                    result.hw_reload = 1'b1;
                    if (tick_expire) begin
                        countdown_next      = 9'd0;
                        running_next        = 1'b0;
                        result.system_reset = 1'b1;
                    end else begin
                        countdown_next = countdown_reg - 9'd1;
                    end
                end
            end
            KIND_OPEN: begin
                if (opened_reg) begin
                    result.status = STATUS_BUSY;
                end else begin
                    opened_next         = 1'b1;
                    countdown_next      = start_count;
                    running_next        = !start_expire;
                    result.hw_reload    = 1'b1;
                    result.system_reset = start_expire;
                end
            end
            KIND_CLOSE: begin
                if (magic_reg) begin
                    running_next   = 1'b0;
                    result.hw_stop = 1'b1;
                end else begin
                    countdown_next      = start_count;
                    running_next        = !start_expire;
                    result.hw_reload    = 1'b1;
                    result.system_reset = start_expire;
                end
                opened_next = 1'b0;
                magic_next  = 1'b0;
            end
            KIND_WRITE: begin
                if (!no_way_out) begin
                    if (item.data_byte == MAGIC_BYTE) begin
                        magic_next = 1'b1;
                    end else if (item.first_of_write) begin
                        magic_next = 1'b0;
                    end
                end
                countdown_next = timeout_reg;
            end
            KIND_KEEPALIVE: begin
                countdown_next = timeout_reg;
            end
            KIND_SET_TIMEOUT: begin
                if (arg_ok) begin
                    timeout_next         = item.argument_value[8:0];
                    countdown_next       = item.argument_value[8:0];
                    result.timeout_value = item.argument_value[8:0];
                end else begin
                    result.status = STATUS_INVALID;
                end
            end
            KIND_GET_TIMEOUT: begin
                result.timeout_value = timeout_reg;
            end
            KIND_SET_OPTIONS: begin
                if (!item.argument_value[OPT_DISABLE] && !item.argument_value[OPT_ENABLE]) begin
                    result.status = STATUS_INVALID;
                end else begin
                    if (item.argument_value[OPT_DISABLE]) begin
                        running_next   = 1'b0;
                        result.hw_stop = 1'b1;
                    end
                    if (item.argument_value[OPT_ENABLE]) begin
                        countdown_next      = start_count;
                        running_next        = !start_expire;
                        result.hw_reload    = 1'b1;
                        result.system_reset = start_expire;
                    end
                end
            end
            default: begin
                result.status = STATUS_OK;
            end
        endcase

        result.is_running = running_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg <= 9'd0;
            running_reg   <= 1'b0;
            opened_reg    <= 1'b0;
            magic_reg     <= 1'b0;
            timeout_reg   <= DEFAULT_TIMEOUT;
        end else if (step) begin
            countdown_reg <= countdown_next;
            running_reg   <= running_next;
            opened_reg    <= opened_next;
            magic_reg     <= magic_next;
            timeout_reg   <= timeout_next;
        end
    end

endmodule

[rtl/watchdog_keepalive_controller.sv]
// ----------------------------------------------------------------------------
// Watchdog keepalive controller
// Software countdown with magic close in front of a hardware watchdog.
// ----------------------------------------------------------------------------
// One event is taken per transfer on the s_ side and gives exactly one result
// transfer on the m_ side, in order. The block takes a new event every cycle
// unless m_tready stalls it: an input register feeds the event logic, which
// writes the state and a result register in the same cycle, so a result goes
// through the input and result registers to m_tdata and holds until m_tready.
// Set no_way_out through the cfg_ channel only while no events are in flight.
module watchdog_keepalive_controller (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: data_byte[7:0], argument_value[17:8], zero pad [23:18]
    input  logic [wdkc_pkg::TDATA_IN_W-1:0]    s_tdata,
    // s_tuser: kind[2:0], first_of_write[3]
    input  logic [wdkc_pkg::TUSER_IN_W-1:0]    s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: status[1:0], timeout_value[10:2], hw_reload[11], hw_stop[12],
    //          system_reset[13], is_running[14], zero pad [15]
    output logic [wdkc_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready
);
    import wdkc_pkg::*;

    item_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;
    logic    no_way_out_reg;
    logic    step;
    logic    s_accept;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !step);
    assign out_valid_next = step || (out_valid_reg && !m_tready);

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            no_way_out_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                no_way_out_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.data_byte      <= s_tdata[7:0];
            in_item_reg.argument_value <= s_tdata[17:8];
            in_item_reg.kind           <= kind_t'(s_tuser[2:0]);
            in_item_reg.first_of_write <= s_tuser[3];
        end
        if (step) begin
            out_reg <= result;
        end
    end

    wdkc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .no_way_out (no_way_out_reg),
        .item       (in_item_reg),
        .result     (result)
    );

    assign m_tdata  = {1'b0, out_reg};
    assign m_tvalid = out_valid_reg;

endmodule

[rtl/wdkc_checker.sv]
// ----------------------------------------------------------------------------
// Watchdog keepalive controller checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "watchdog_keepalive_controller_defines.svh"

module wdkc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic [wdkc_pkg::TDATA_OUT_W-1:0]   m_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready
);
    import wdkc_pkg::*;

    result_t res;

    assign res = result_t'(m_tdata[TDATA_OUT_W-2:0]);

    // A stalled result holds
    `WDKC_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Expiry always comes with a reload pulse and leaves the countdown stopped
    `WDKC_ASSERT_NOW(a_expire_stops, aclk, aresetn, m_tvalid && res.system_reset, res.hw_reload && !res.is_running)

    // Busy or invalid events touch nothing
    `WDKC_ASSERT_NOW(a_reject_quiet, aclk, aresetn, m_tvalid && (res.status != STATUS_OK), !res.hw_reload && !res.hw_stop && !res.system_reset && (res.timeout_value == 9'd0))

    // A stop without a restart leaves the block stopped
    `WDKC_ASSERT_NOW(a_stop_idle, aclk, aresetn, m_tvalid && res.hw_stop && !res.hw_reload, !res.is_running)

endmodule

bind watchdog_keepalive_controller wdkc_checker u_wdkc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
